// ----- hdl/chdf_pkg.sv -----
// Package for the credential header deframer: shared widths, constants,
// the status code type and the record passed from front end to back end.
// No dependencies.
`default_nettype none

package chdf_pkg;

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int VER_W     = 4;
    localparam int METHOD_W  = 11;
    localparam int MACC_W    = 10;
    localparam int LEN_W     = 14;
    localparam int CNT_W     = 14;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 14;

    // Header layout defaults
    localparam int METHOD_DIGITS_DEF = 3;
    localparam int LENGTH_DIGITS_DEF = 4;

    // Depth of the queue between front end and back end
    localparam int QUEUE_DEPTH_DEF = 4;

    // Character and counter constants
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT   = 2'd2;

    // Configuration reset values
    localparam logic [VER_W-1:0] VERSION_LOW_RST  = 4'd1;
    localparam logic [VER_W-1:0] VERSION_HIGH_RST = 4'd9;
    localparam logic [LEN_W-1:0] BODY_LIMIT_RST   = 14'd1024;

    // Final status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_LENGTH  = 3'd3,
        ST_TRUNCATED   = 3'd4
    } t_status;

    // Classified transaction from front end to back end
    typedef struct packed {
        logic [CHAR_W-1:0] body_char;
        logic              passed;
        logic              eom;
        logic              too_short;
        logic              version_ok;
        logic              length_ok;
        logic              body_short;
        logic [VER_W-1:0]  version;
        logic [MACC_W-1:0] method_acc;
        logic              method_bad;
        logic [LEN_W-1:0]  length_acc;
    } t_rec;

endpackage

`default_nettype wire

// ----- hdl/chdf_front.sv -----
// Front end: holds configuration, parses header bytes, counts body bytes
// and classifies each byte into a transaction record. Uses chdf_pkg.
`default_nettype none

module chdf_front
    import chdf_pkg::*;
#(
    parameter int METHOD_DIGITS = METHOD_DIGITS_DEF,
    parameter int LENGTH_DIGITS = LENGTH_DIGITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic [CHAR_W-1:0]    i_char_in,
    input  wire logic                 i_end_of_message,
    output logic                      o_rec_push,
    output t_rec                      o_rec
);

    localparam logic [CNT_W-1:0] METHOD_END = CNT_W'(METHOD_DIGITS);
    localparam logic [CNT_W-1:0] LENGTH_END = CNT_W'(METHOD_DIGITS + LENGTH_DIGITS);
    localparam logic [CNT_W-1:0] HDR_LEN    = CNT_W'(1 + METHOD_DIGITS + LENGTH_DIGITS);

    logic [VER_W-1:0]  r_version_low;
    logic [VER_W-1:0]  r_version_high;
    logic [LEN_W-1:0]  r_body_limit;

    logic [CNT_W-1:0]  r_pos,         n_pos;
    logic [VER_W-1:0]  r_version,     n_version;
    logic              r_version_bad, n_version_bad;
    logic [MACC_W-1:0] r_method,      n_method;
    logic              r_method_bad,  n_method_bad;
    logic [LEN_W-1:0]  r_length,      n_length;
    logic              r_length_bad,  n_length_bad;
    logic [CNT_W-1:0]  r_body_count,  n_body_count;

    logic              digit;
    logic [VER_W-1:0]  digit_val;
    logic              passed;
    logic              cur_version_ok;
    logic              cur_length_ok;
    logic              nxt_version_ok;
    logic              nxt_length_ok;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version_low  <= VERSION_LOW_RST;
            r_version_high <= VERSION_HIGH_RST;
            r_body_limit   <= BODY_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VERSION_LOW:  r_version_low  <= i_cfg_data[VER_W-1:0];
                CFG_VERSION_HIGH: r_version_high <= i_cfg_data[VER_W-1:0];
                CFG_BODY_LIMIT:   r_body_limit   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the incoming byte
    assign digit     = (i_char_in >= CHAR_ZERO) && (i_char_in <= CHAR_NINE);
    assign digit_val = digit ? VER_W'(i_char_in - CHAR_ZERO) : '0;

    // Header checks on held state; valid for body bytes
    assign cur_version_ok = !r_version_bad && (r_version >= r_version_low)
                            && (r_version <= r_version_high);
    assign cur_length_ok  = !r_length_bad && (r_length <= r_body_limit);

    // Advance the parser by one byte
    always_comb begin
        n_pos         = r_pos;
        n_version     = r_version;
        n_version_bad = r_version_bad;
        n_method      = r_method;
        n_method_bad  = r_method_bad;
        n_length      = r_length;
        n_length_bad  = r_length_bad;
        n_body_count  = r_body_count;
        passed        = 1'b0;
        if (r_pos == '0) begin
            n_version     = digit_val;
            n_version_bad = !digit;
        end else if (r_pos <= METHOD_END) begin
            if (digit) begin
                n_method = MACC_W'((r_method << 3) + (r_method << 1) + MACC_W'(digit_val));
            end else begin
                n_method_bad = 1'b1;
            end
        end else if (r_pos <= LENGTH_END) begin
            if (digit) begin
                n_length = LEN_W'((r_length << 3) + (r_length << 1) + LEN_W'(digit_val));
            end else begin
                n_length_bad = 1'b1;
            end
        end else begin
            passed = cur_version_ok && cur_length_ok && (r_body_count < r_length);
            if (r_body_count != CNT_MAX) begin
                n_body_count = r_body_count + 1'b1;
            end
        end
        if (r_pos != CNT_MAX) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // Header checks on updated state for the final transaction
    assign nxt_version_ok = !n_version_bad && (n_version >= r_version_low)
                            && (n_version <= r_version_high);
    assign nxt_length_ok  = !n_length_bad && (n_length <= r_body_limit);

    // Update parser state; clear after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_message)) begin
            r_pos         <= '0;
            r_version     <= '0;
            r_version_bad <= 1'b0;
            r_method      <= '0;
            r_method_bad  <= 1'b0;
            r_length      <= '0;
            r_length_bad  <= 1'b0;
            r_body_count  <= '0;
        end else if (i_accept) begin
            r_pos         <= n_pos;
            r_version     <= n_version;
            r_version_bad <= n_version_bad;
            r_method      <= n_method;
            r_method_bad  <= n_method_bad;
            r_length      <= n_length;
            r_length_bad  <= n_length_bad;
            r_body_count  <= n_body_count;
        end
    end

    // Build the transaction record
    always_comb begin
        o_rec.body_char  = i_char_in;
        o_rec.passed     = passed;
        o_rec.eom        = i_end_of_message;
        o_rec.too_short  = n_pos < HDR_LEN;
        o_rec.version_ok = nxt_version_ok;
        o_rec.length_ok  = nxt_length_ok;
        o_rec.body_short = n_body_count < n_length;
        o_rec.version    = n_version;
        o_rec.method_acc = n_method;
        o_rec.method_bad = n_method_bad;
        o_rec.length_acc = n_length;
    end

    assign o_rec_push = i_accept && (i_end_of_message || passed);

endmodule

`default_nettype wire

// ----- hdl/chdf_queue.sv -----
// Short queue of transaction records between front end and back end.
// Uses chdf_pkg for the record type.
`default_nettype none

module chdf_queue
    import chdf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_rec      i_rec,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_rec      o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    t_rec              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/chdf_back.sv -----
// Back end: resolves status priority, masks meaningless fields and holds
// the result in an output register. Uses chdf_pkg.
`default_nettype none

module chdf_back
    import chdf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rec_valid,
    input  t_rec                     i_rec,
    output logic                     o_rec_pop,
    output logic                     o_empty,
    input  wire logic                i_pop,
    output logic [CHAR_W-1:0]        o_body_char,
    output logic                     o_body_char_valid,
    output logic                     o_done_res,
    output logic [STATUS_W-1:0]      o_status,
    output logic [VER_W-1:0]         o_version,
    output logic signed [METHOD_W-1:0] o_method,
    output logic [LEN_W-1:0]         o_body_length
);

    logic                       r_valid;
    logic [CHAR_W-1:0]          r_body_char;
    logic                       r_body_valid;
    logic                       r_done;
    t_status                    r_status;
    logic [VER_W-1:0]           r_version;
    logic signed [METHOD_W-1:0] r_method;
    logic [LEN_W-1:0]           r_length;

    t_status                    n_status;
    logic                       load;
    logic                       hdr_fields;
    logic                       len_field;
    logic signed [METHOD_W-1:0] method_val;

    // Load when the output register is free or being drained
    assign load      = i_rec_valid && (!r_valid || i_pop);
    assign o_rec_pop = load;

    // Resolve status by priority
    always_comb begin
        if (!i_rec.eom) begin
            n_status = ST_OK;
        end else if (i_rec.too_short) begin
            n_status = ST_TOO_SHORT;
        end else if (!i_rec.version_ok) begin
            n_status = ST_BAD_VERSION;
        end else if (!i_rec.length_ok) begin
            n_status = ST_BAD_LENGTH;
        end else if (i_rec.body_short) begin
            n_status = ST_TRUNCATED;
        end else begin
            n_status = ST_OK;
        end
    end

    // Decide which fields carry meaning
    assign hdr_fields = i_rec.eom && (n_status != ST_TOO_SHORT)
                        && (n_status != ST_BAD_VERSION);
    assign len_field  = i_rec.eom && ((n_status == ST_OK) || (n_status == ST_TRUNCATED));
    assign method_val = i_rec.method_bad ? '1 : $signed({1'b0, i_rec.method_acc});

    // Hold output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Capture result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_body_char  <= i_rec.passed ? i_rec.body_char : '0;
            r_body_valid <= i_rec.passed;
            r_done       <= i_rec.eom;
            r_status     <= n_status;
            r_version    <= hdr_fields ? i_rec.version : '0;
            r_method     <= hdr_fields ? method_val : '0;
            r_length     <= len_field ? i_rec.length_acc : '0;
        end
    end

    assign o_empty           = !r_valid;
    assign o_body_char       = r_body_char;
    assign o_body_char_valid = r_body_valid;
    assign o_done_res        = r_done;
    assign o_status          = r_status;
    assign o_version         = r_version;
    assign o_method          = r_method;
    assign o_body_length     = r_length;

endmodule

`default_nettype wire

// ----- hdl/credential_header_deframer_unit.sv -----
// Path: the byte that causes a result enters the queue at the edge that accepts it;
// the result then moves from the queue into the output register when that register
// is free or being popped.
// Throughput: one byte per cycle while full is low; the queue and output register let
// the input keep flowing while a result waits to be popped.
// Reset: synchronous, active low; clears parser state, queue and output valid,
// and loads the configuration registers with their defaults.
`default_nettype none

module credential_header_deframer_unit
    import chdf_pkg::*;
#(
    parameter int METHOD_DIGITS = METHOD_DIGITS_DEF,
    parameter int LENGTH_DIGITS = LENGTH_DIGITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [CHAR_W-1:0]     i_char_in,
    input  wire logic                  i_end_of_message,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [CHAR_W-1:0]          o_body_char,
    output logic                       o_body_char_valid,
    output logic                       o_done_res,
    output logic [STATUS_W-1:0]        o_status,
    output logic [VER_W-1:0]           o_version,
    output logic signed [METHOD_W-1:0] o_method,
    output logic [LEN_W-1:0]           o_body_length
);

    logic accept;
    logic rec_push;
    t_rec front_rec;
    logic q_valid;
    t_rec q_rec;
    logic q_pop;

    assign accept = push && !full;

    // Parse and classify bytes
    chdf_front #(
        .METHOD_DIGITS(METHOD_DIGITS),
        .LENGTH_DIGITS(LENGTH_DIGITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_char_in       (i_char_in),
        .i_end_of_message(i_end_of_message),
        .o_rec_push      (rec_push),
        .o_rec           (front_rec)
    );

    // Decouple front end from back end
    chdf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (rec_push),
        .i_rec  (front_rec),
        .o_full (full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_rec  (q_rec)
    );

    // Format and hold results
    chdf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec_valid      (q_valid),
        .i_rec            (q_rec),
        .o_rec_pop        (q_pop),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_body_char      (o_body_char),
        .o_body_char_valid(o_body_char_valid),
        .o_done_res       (o_done_res),
        .o_status         (o_status),
        .o_version        (o_version),
        .o_method         (o_method),
        .o_body_length    (o_body_length)
    );

endmodule

`default_nettype wire

// ----- hdl/chdf_checker.sv -----
// Port-level checks for the credential header deframer, bound to the top level.
// Uses chdf_pkg for widths and status codes.
`default_nettype none

module chdf_checker
    import chdf_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  empty,
    input wire logic                  pop,
    input wire logic [CHAR_W-1:0]     o_body_char,
    input wire logic                  o_body_char_valid,
    input wire logic                  o_done_res,
    input wire logic [STATUS_W-1:0]   o_status,
    input wire logic [VER_W-1:0]      o_version,
    input wire logic [METHOD_W-1:0]   o_method,
    input wire logic [LEN_W-1:0]      o_body_length
);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_body_char) && $stable(o_status)
                              && $stable(o_done_res)))
        else $error("stalled result changed");

    // Every result carries a body byte or closes a message
    a_result_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_done_res) |-> (o_body_char_valid && o_status == ST_OK
                                     && o_body_length == '0))
        else $error("result with no body byte and no end of message");

    // Dropped body byte reads as zero
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_body_char_valid) |-> (o_body_char == '0))
        else $error("body char nonzero without valid");

    // Header fields are zero when the header was rejected early
    a_hdr_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_TOO_SHORT || o_status == ST_BAD_VERSION))
        |-> (o_version == '0 && o_method == '0 && o_body_length == '0))
        else $error("header fields not cleared on early rejection");

endmodule

bind credential_header_deframer_unit chdf_checker u_chdf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_body_char      (o_body_char),
    .o_body_char_valid(o_body_char_valid),
    .o_done_res       (o_done_res),
    .o_status         (o_status),
    .o_version        (o_version),
    .o_method         (o_method),
    .o_body_length    (o_body_length)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for credential_header_deframer_unit: byte stream in through
// the push/full queue port, results out through the empty/pop port, checked against
// a cycle-free predictor. Depends on chdf_pkg and the deframer RTL.
module tb_top
    import chdf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEADER_BYTES   = 1 + METHOD_DIGITS_DEF + LENGTH_DIGITS_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int RAND_PER_PHASE = 240;
    localparam int LONG_MSG_BYTES = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] body_char;
        logic              valid;
        logic              done;
        t_status           status;
        logic [VER_W-1:0]  version;
        logic [METHOD_W-1:0] method;
        logic [LEN_W-1:0]  body_length;
    } t_result;

    typedef struct packed {
        logic [CHAR_W-1:0] c;
        logic              eom;
        logic              typed;
        t_result           want;
    } t_row;

    // DUT connections
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  push;
    logic                  full;
    logic [CHAR_W-1:0]     i_char_in;
    logic                  i_end_of_message;
    logic                  empty;
    logic                  pop;
    logic [CHAR_W-1:0]     o_body_char;
    logic                  o_body_char_valid;
    logic                  o_done_res;
    logic [STATUS_W-1:0]   o_status;
    logic [VER_W-1:0]      o_version;
    logic signed [METHOD_W-1:0] o_method;
    logic [LEN_W-1:0]      o_body_length;

    // Predictor copy of the configuration and parser state
    logic [VER_W-1:0]  win_lo;
    logic [VER_W-1:0]  win_hi;
    logic [LEN_W-1:0]  len_cap;
    logic [CNT_W-1:0]  hdr_pos;
    logic [VER_W-1:0]  ver_digit;
    logic              ver_bad;
    logic [MACC_W-1:0] meth_acc;
    logic              meth_bad;
    logic [LEN_W-1:0]  len_acc;
    logic              len_bad;
    logic [CNT_W-1:0]  body_seen;

    t_result due_results[$];
    t_row    dir_rows[$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      tx_burst   = 1'b0;
    bit      rx_burst   = 1'b0;
    bit      tx_calm    = 1'b0;

    credential_header_deframer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_char_in         (i_char_in),
        .i_end_of_message  (i_end_of_message),
        .empty             (empty),
        .pop               (pop),
        .o_body_char       (o_body_char),
        .o_body_char_valid (o_body_char_valid),
        .o_done_res        (o_done_res),
        .o_status          (o_status),
        .o_version         (o_version),
        .o_method          (o_method),
        .o_body_length     (o_body_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_msg();
        hdr_pos   = '0;
        ver_digit = '0;
        ver_bad   = 1'b0;
        meth_acc  = '0;
        meth_bad  = 1'b0;
        len_acc   = '0;
        len_bad   = 1'b0;
        body_seen = '0;
    endfunction

    // Advance the parser by one byte; return 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [CHAR_W-1:0] c, input logic eom,
                                        output t_result r);
        logic             is_digit;
        logic             passed;
        logic             ver_good;
        logic             len_good;
        logic [VER_W-1:0] d;
        t_status          st;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d        = is_digit ? VER_W'(c - CHAR_ZERO) : '0;
        passed   = 1'b0;
        r        = '0;

        // Accumulate the header fields
        if (hdr_pos == 0) begin
            ver_digit = d;
            ver_bad   = !is_digit;
        end else if (hdr_pos <= METHOD_DIGITS_DEF) begin
            if (is_digit) meth_acc = MACC_W'(meth_acc * 10 + d);
            else meth_bad = 1'b1;
        end else if (hdr_pos <= METHOD_DIGITS_DEF + LENGTH_DIGITS_DEF) begin
            if (is_digit) len_acc = LEN_W'(len_acc * 10 + d);
            else len_bad = 1'b1;
        end
        ver_good = !ver_bad && ver_digit >= win_lo && ver_digit <= win_hi;
        len_good = !len_bad && len_acc <= len_cap;

        // Pass body bytes within the declared length, drop the rest
        if (hdr_pos > METHOD_DIGITS_DEF + LENGTH_DIGITS_DEF) begin
            passed = ver_good && len_good && body_seen < len_acc;
            if (body_seen != CNT_MAX) body_seen++;
        end
        if (hdr_pos != CNT_MAX) hdr_pos++;

        if (!eom && !passed) return 1'b0;
        if (passed) begin
            r.body_char = c;
            r.valid     = 1'b1;
        end
        if (eom) begin
            if (hdr_pos < HEADER_BYTES) st = ST_TOO_SHORT;
            else if (!ver_good) st = ST_BAD_VERSION;
            else if (!len_good) st = ST_BAD_LENGTH;
            else if (body_seen < len_acc) st = ST_TRUNCATED;
            else st = ST_OK;
            r.done   = 1'b1;
            r.status = st;
            if (st != ST_TOO_SHORT && st != ST_BAD_VERSION) begin
                r.version = ver_digit;
                r.method  = meth_bad ? '1 : {1'b0, meth_acc};
            end
            if (st == ST_OK || st == ST_TRUNCATED) r.body_length = len_acc;
            clear_msg();
        end
        return 1'b1;
    endfunction

    function automatic t_result typed_result(input logic [CHAR_W-1:0] bc, input logic v,
                                             input logic dn, input t_status st,
                                             input int ver, input int meth, input int blen);
        t_result r;
        r.body_char   = bc;
        r.valid       = v;
        r.done        = dn;
        r.status      = st;
        r.version     = VER_W'(ver);
        r.method      = METHOD_W'(meth);
        r.body_length = LEN_W'(blen);
        return r;
    endfunction

    function automatic void add_row(input logic [CHAR_W-1:0] c, input logic eom,
                                    input logic typed, input t_result want);
        t_row row;
        row.c     = c;
        row.eom   = eom;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_text(input string s);
        foreach (s[j]) add_row(s[j], 1'b0, 1'b0, '0);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_or_junk(input int odds);
        if ($urandom_range(0, odds - 1) == 0) return CHAR_W'($urandom);
        return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Offer one byte after a random gap, hold it until accepted, then predict
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eom,
                             input logic typed, input t_result want);
        int      gap;
        t_result predicted;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = (tx_burst || tx_calm) ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push             = 1'b1;
        i_char_in        = c;
        i_end_of_message = eom;
        do @(posedge i_clk); while (full !== 1'b0);
        items_sent++;
        if (deframe_byte(c, eom, predicted) || typed)
            due_results.push_back(typed ? want : predicted);
    endtask

    // Drop push and wait until every expected result is out and the pipe is empty
    task automatic settle();
        @(negedge i_clk);
        push = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_VERSION_LOW:  win_lo  = value[VER_W-1:0];
            CFG_VERSION_HIGH: win_hi  = value[VER_W-1:0];
            CFG_BODY_LIMIT:   len_cap = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly well-formed messages with random content, some noise and cut-off ones
    task automatic random_traffic(input int target);
        logic [CHAR_W-1:0] msg[$];
        int first;
        int decl;
        int nbody;
        int k;
        first = items_sent;
        while (items_sent - first < target) begin
            msg.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) msg.push_back(CHAR_W'($urandom));
            end else begin
                msg.push_back(digit_or_junk(16));
                repeat (METHOD_DIGITS_DEF) msg.push_back(digit_or_junk(20));
                case ($urandom_range(0, 19))
                    0:       decl = $urandom_range(int'(len_cap), 9999);
                    1:       decl = $urandom_range(0, int'(len_cap));
                    2:       decl = len_cap;
                    default: decl = $urandom_range(0, 12);
                endcase
                for (k = 10 ** (LENGTH_DIGITS_DEF - 1); k > 0; k /= 10) begin
                    if ($urandom_range(0, 24) == 0) msg.push_back(CHAR_W'($urandom));
                    else msg.push_back(CHAR_ZERO + CHAR_W'((decl / k) % 10));
                end
                // Keep bodies short; large declared lengths end up truncated
                nbody = (decl < 24) ? decl : 24;
                if ($urandom_range(0, 3) == 0) nbody -= $urandom_range(0, 2);
                else nbody += $urandom_range(0, 3);
                for (k = 0; k < nbody; k++) msg.push_back(CHAR_W'($urandom));
                if ($urandom_range(0, 9) == 0)
                    while (msg.size() > 1 && $urandom_range(0, 3) != 0) void'(msg.pop_back());
            end
            foreach (msg[j]) send_byte(msg[j], j == msg.size() - 1, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int lo, input int hi, input int cap);
        write_reg(CFG_VERSION_LOW, CFG_W'(lo));
        write_reg(CFG_VERSION_HIGH, CFG_W'(hi));
        write_reg(CFG_BODY_LIMIT, CFG_W'(cap));
        random_traffic(RAND_PER_PHASE);
        settle();
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result, body_char %02h done %0b",
                                      got.body_char, got.done));
            return;
        end
        want = due_results.pop_front();
        if (got.body_char !== want.body_char)
            report_mismatch($sformatf("body_char got %02h want %02h",
                                      got.body_char, want.body_char));
        if (got.valid !== want.valid)
            report_mismatch($sformatf("body_char_valid got %0b want %0b", got.valid, want.valid));
        if (got.done !== want.done)
            report_mismatch($sformatf("done_res got %0b want %0b", got.done, want.done));
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.version !== want.version)
            report_mismatch($sformatf("version got %0d want %0d", got.version, want.version));
        if (got.method !== want.method)
            report_mismatch($sformatf("method got %0d want %0d",
                                      $signed(got.method), $signed(want.method)));
        if (got.body_length !== want.body_length)
            report_mismatch($sformatf("body_length got %0d want %0d",
                                      got.body_length, want.body_length));
    endtask

    // Result side: random pop gaps, check every popped transaction
    initial begin : result_sink
        t_result got;
        int      gap;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 12);
            @(negedge i_clk);
            if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            got.body_char   = o_body_char;
            got.valid       = o_body_char_valid;
            got.done        = o_done_res;
            got.status      = t_status'(o_status);
            got.version     = o_version;
            got.method      = o_method;
            got.body_length = o_body_length;
            check_result(got);
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0)) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int n;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        push             = 1'b0;
        i_char_in        = '0;
        i_end_of_message = 1'b0;
        win_lo           = VERSION_LOW_RST;
        win_hi           = VERSION_HIGH_RST;
        len_cap          = BODY_LIMIT_RST;
        clear_msg();

        // Directed messages under reset configuration
        add_row(8'h00, 1'b1, 1'b1, typed_result(8'h00, 1'b0, 1'b1, ST_TOO_SHORT, 0, 0, 0));
        add_text("/12:00x");
        add_row("1", 1'b1, 1'b1, typed_result(8'h00, 1'b0, 1'b1, ST_BAD_VERSION, 0, 0, 0));
        add_text("1000999");
        add_row("9", 1'b1, 1'b1, typed_result(8'h00, 1'b0, 1'b1, ST_BAD_LENGTH, 1, 0, 0));
        // Final byte that is also a passed body byte
        add_text("99990001");
        add_row(8'hFF, 1'b1, 1'b1, typed_result(8'hFF, 1'b1, 1'b1, ST_OK, 9, 999, 1));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[j])
            send_byte(dir_rows[j].c, dir_rows[j].eom, dir_rows[j].typed, dir_rows[j].want);
        settle();

        // Long message sent back to back: bytes past the declared length are dropped
        tx_calm = 1'b1;
        for (n = 0; n < LONG_MSG_BYTES; n++)
            send_byte(n == 0 ? CHAR_ZERO + 8'd1 :
                      n < HEADER_BYTES - 1 ? CHAR_ZERO :
                      n == HEADER_BYTES - 1 ? CHAR_ZERO + 8'd5 : CHAR_W'($urandom),
                      n == LONG_MSG_BYTES - 1, 1'b0, '0);
        tx_calm = 1'b0;
        settle();

        random_traffic(RAND_PER_PHASE);
        settle();
        run_phase(0, 9, 9999);
        run_phase(0, 0, 0);
        run_phase(9, 9, 5);
        // Empty version window: every version is rejected
        run_phase(5, 3, 20);
        run_phase($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 60));
        run_phase(VERSION_LOW_RST, VERSION_HIGH_RST, BODY_LIMIT_RST);

        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
